[rtl/assert_macros.svh]
// Assertion macros for the RTL; only the top-level hasher includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [3:0]  LengthSlot = 4'd14;
  localparam logic [31:0] PadWord    = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sha_state_e;

  // absorb sources
  typedef enum logic [1:0] {
    SRC_INPUT,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sha_src_e;

  typedef struct packed {
    logic     absorb;     // write a word into the block buffer
    sha_src_e src;
    logic     add_len;    // add accepted byte count to the bit length
    logic     load_vars;  // copy chain value into round variables
    logic     round;      // run one round
    logic     fold;       // add round variables into chain value
    logic     restart;    // back to the initial hash values
    logic     emit_shift; // advance the digest output
  } sha_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic [5:0] round;
  } sha_status_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: absorb, padding, 64 rounds, fold and digest emission.
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  input  logic [2:0]  in_count_i,
  input  logic        out_ready_i,
  input  sha_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output logic [2:0]  out_index_o,
  output sha_cmd_t    cmd_o
);

  sha_state_e state_q, state_d;
  logic       final_q, final_d;   // padding under way for a last word
  logic       lenpend_q, lenpend_d; // high length word not yet written
  logic [2:0] idx_q, idx_d;
  logic       accept;

  assign out_index_o = idx_q;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      final_q   <= 1'b0;
      lenpend_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      final_q   <= final_d;
      lenpend_q <= lenpend_d;
      idx_q     <= idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    final_d     = final_q;
    lenpend_d   = lenpend_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.src   = SRC_INPUT;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.add_len = 1'b1;
          cmd_o.absorb  = 1'b1;
          if (in_last_i) begin
            final_d   = 1'b1;
            lenpend_d = 1'b1;
            // a full last word still needs the marker word
            if (in_count_i >= 3'd4) begin
              state_d = (status_i.fill == 4'd15) ? ST_ROUND : ST_PAD;
              final_d = 1'b0; // marker not yet written
            end else begin
              state_d = (status_i.fill == 4'd15) ? ST_ROUND : ST_PAD;
            end
          end else if (status_i.fill == 4'd15) begin
            state_d = ST_ROUND;
          end
          if (status_i.fill == 4'd15) cmd_o.load_vars = 1'b1;
        end
      end
      ST_PAD: begin
        // final_q low: marker word pending; else zeros then length
        cmd_o.absorb = 1'b1;
        if (!final_q) begin
          cmd_o.src = SRC_INPUT; // datapath substitutes the marker
          final_d   = 1'b1;
        end else if (status_i.fill == LengthSlot) begin
          cmd_o.src = SRC_LEN_HI;
          lenpend_d = 1'b0;
        end else if (status_i.fill == 4'd15 && !lenpend_q) begin
          cmd_o.src = SRC_LEN_LO;
        end else begin
          cmd_o.src = SRC_ZERO;
        end
        if (status_i.fill == 4'd15) begin
          cmd_o.load_vars = 1'b1;
          state_d         = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (status_i.round == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (lenpend_q || (final_q && !lenpend_q && 1'b0)) begin
          state_d = ST_PAD;
        end else if (final_q) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end else if (lenpend_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
        // marker still pending after a full last word filled the block
        if (!final_q && lenpend_q) state_d = ST_PAD;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_shift = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            final_d       = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/sha_datapath.sv]
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, schedule, round variables, chain value and bit counter.
// ----------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic        marker_i,  // current pad absorb writes the marker word
  input  logic [31:0] in_word_i,
  input  logic [2:0]  in_count_i,
  input  logic        in_last_i,
  output sha_status_t status_o,
  output logic [31:0] digest_o
);

  logic [31:0] w_q [BlockWords];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] len_q;
  logic [3:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  cnt;
  logic [31:0] keep, absorb_word, wv, w15, w2, w7, t1, t2;
  logic [63:0] len_now;

  assign status_o.fill  = fill_q;
  assign status_o.round = rnd_q;
  assign digest_o       = h_q[0];

  // saturate count; non-last words are full
  assign cnt = (!in_last_i || in_count_i > 3'd4) ? 3'd4 : in_count_i;
  assign len_now = len_q;

  always_comb begin
    keep = (cnt == 3'd0) ? 32'h0 : ~(32'hffff_ffff >> {cnt, 3'b000});
    case (cmd_i.src)
      SRC_INPUT: begin
        if (marker_i) absorb_word = PadWord;
        else if (cnt == 3'd4) absorb_word = in_word_i;
        else absorb_word = (in_word_i & keep) | (PadWord >> {cnt, 3'b000});
      end
      SRC_ZERO:   absorb_word = '0;
      SRC_LEN_HI: absorb_word = len_now[63:32];
      SRC_LEN_LO: absorb_word = len_now[31:0];
      default:    absorb_word = '0;
    endcase
    w15 = w_q[4'(rnd_q + 6'd1)];
    w2  = w_q[4'(rnd_q + 6'd14)];
    w7  = w_q[4'(rnd_q + 6'd9)];
    if (rnd_q < 6'd16) wv = w_q[rnd_q[3:0]];
    else wv = w_q[rnd_q[3:0]] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w7
            + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
    t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundConst[rnd_q] + wv;
    t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) w_q[fill_q] <= absorb_word;
    if (cmd_i.round) begin
      w_q[rnd_q[3:0]] <= wv;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
    if (cmd_i.load_vars) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      len_q  <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.add_len) len_q <= len_q + {58'd0, cnt, 3'b000};
      if (cmd_i.absorb) fill_q <= fill_q + 4'd1;
      if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        len_q  <= '0;
        fill_q <= '0;
      end else if (cmd_i.emit_shift) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i + 1];
        h_q[7] <= h_q[0];
      end
    end
  end

endmodule

[rtl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a word stream with built-in padding; eight digest words out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | tlast
//  s_axis  | in  | [31:0] msg_word               | [2:0] count | last_word
//  m_axis  | out | [31:0] digest_word,[34:32] ix | -           | digest_end
//
// A word is absorbed directly unless it fills a 16-word block; then 64 rounds
// (one round per cycle in a single round unit) and one fold follow, and no
// new word is accepted until the fold is done.
// A last word adds padding absorbs to the end of its block, possibly a
// second padding block, then the eight digest words are output. Reset restores
// the initial hash values; output stalls hold the digest word in place.
`include "assert_macros.svh"
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] msg_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // digest_end
);

  sha_cmd_t    cmd;
  sha_status_t status;
  logic [2:0]  index;
  logic [31:0] digest;
  logic        marker;

  // pad cycle writing the marker after a full last word
  assign marker = (cmd.src == SRC_INPUT) && cmd.absorb && !s_axis_tready;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_count_i (s_axis_tuser),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_index_o(index),
    .cmd_o      (cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .marker_i  (marker),
    .in_word_i (s_axis_tdata),
    .in_count_i(s_axis_tuser),
    .in_last_i (s_axis_tlast),
    .status_o  (status),
    .digest_o  (digest)
  );

  assign m_axis_tdata = {5'd0, index, digest};
  assign m_axis_tlast = (index == 3'd7);

  `ASSERT_IMPLIES(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `ASSERT_NEXT(a_round_adv, clk_i, rst_ni, cmd.round && status.round != 6'd63,
               status.round == $past(status.round) + 6'd1)
  `ASSERT_IMPLIES(a_one_op, clk_i, rst_ni, cmd.round, !cmd.absorb && !cmd.fold)

endmodule
